// ===== rtl/mdte_pkg.sv =====
// ----------------------------------------------------------------------------
// mdte_pkg: shared types and constants of the DMA transfer engine
// Holds the region table, operation and result kind codes, and the
// command record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package mdte_pkg;

    localparam int COUNT_BITS     = 24;
    localparam int DISC_MAX_STEPS = 1024;
    localparam int OFF_W          = 21;
    localparam int NREGIONS       = 15;

    localparam logic [2:0] OP_COPY       = 3'd0;
    localparam logic [2:0] OP_COPY_SPLIT = 3'd1;
    localparam logic [2:0] OP_DISC       = 3'd2;
    localparam logic [2:0] OP_DISC_SPLIT = 3'd3;
    localparam logic [2:0] OP_FILL       = 3'd4;
    localparam logic [2:0] OP_FILL_SPLIT = 3'd5;
    localparam logic [2:0] OP_PATTERN    = 3'd6;

    localparam logic [2:0] K_WRITE    = 3'd0;
    localparam logic [2:0] K_READ     = 3'd1;
    localparam logic [2:0] K_DROP     = 3'd2;
    localparam logic [2:0] K_START    = 3'd3;
    localparam logic [2:0] K_BADMODE  = 3'd4;
    localparam logic [2:0] K_NOREGION = 3'd5;
    localparam logic [2:0] K_IDLE     = 3'd6;
    localparam logic [2:0] K_EMPTY    = 3'd7;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_FIRST   = 3'd1;
    localparam logic [2:0] REG_SECOND  = 3'd2;
    localparam logic [2:0] REG_COUNT   = 3'd3;
    localparam logic [2:0] REG_PATTERN = 3'd4;

    // Classified transaction handed to the back end
    typedef struct packed {
        logic        is_step;     // 1: step, 0: start
        logic [2:0]  kind;        // start outcome
        logic [2:0]  op;
        logic [3:0]  wr_region;
        logic [3:0]  rd_region;
        logic [OFF_W-1:0] wr_off;
        logic [OFF_W-1:0] rd_off;
        logic [COUNT_BITS-1:0] count;
        logic [31:0] fill_addr;
        logic [15:0] word;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [3:0]       region;
        logic [OFF_W-1:0] offset;
        logic [15:0]      data;
        logic             last;
    } res_t;

    function automatic logic [OFF_W-1:0] region_mask(input logic [3:0] r);
        logic [OFF_W-1:0] m;
        case (r)
            4'd0:    m = 21'h1FFFFF;
            4'd1:    m = 21'h000001;
            4'd2:    m = 21'h000001;
            4'd3:    m = 21'h000001;
            4'd4:    m = 21'h000001;
            4'd5:    m = 21'h00001F;
            4'd6:    m = 21'h00000F;
            4'd7:    m = 21'h001FFF;
            4'd8:    m = 21'h003FFF;
            4'd9:    m = 21'h07FFFF;
            4'd10:   m = 21'h0FFFFF;
            4'd11:   m = 21'h0001FF;
            default: m = 21'h000000;
        endcase
        return m;
    endfunction

    function automatic logic region_write_ok(input logic [3:0] r);
        return (r <= 4'd11) && (r != 4'd9);
    endfunction

    function automatic logic region_read_ok(input logic [3:0] r);
        return r <= 4'd11;
    endfunction

    // Region lookup on the low 24 address bits; valid flag plus index
    function automatic logic [4:0] find_region(input logic [31:0] addr);
        logic [23:0] a;
        logic [4:0]  f;
        a = addr[23:0];
        if (a <= 24'h1FFFFF)                         f = {1'b1, 4'd0};
        else if (a >= 24'h300000 && a <= 24'h31FFFF) f = {1'b1, 4'd1};
        else if (a >= 24'h320000 && a <= 24'h33FFFF) f = {1'b1, 4'd2};
        else if (a >= 24'h340000 && a <= 24'h35FFFF) f = {1'b1, 4'd3};
        else if (a >= 24'h380000 && a <= 24'h39FFFF) f = {1'b1, 4'd4};
        else if (a >= 24'h3A0000 && a <= 24'h3BFFFF) f = {1'b1, 4'd5};
        else if (a >= 24'h3C0000 && a <= 24'h3DFFFF) f = {1'b1, 4'd6};
        else if (a >= 24'h400000 && a <= 24'h4FFFFF) f = {1'b1, 4'd7};
        else if (a >= 24'h800000 && a <= 24'h8FFFFF) f = {1'b1, 4'd8};
        else if (a >= 24'hC00000 && a <= 24'hCFFFFF) f = {1'b1, 4'd9};
        else if (a >= 24'hE00000 && a <= 24'hEFFFFF) f = {1'b1, 4'd10};
        else if (a >= 24'hFF0000 && a <= 24'hFF01FF) f = {1'b1, 4'd11};
        else if (a >= 24'h200000 && a <= 24'h2FFFFF) f = {1'b1, 4'd12};
        else if (a >= 24'h360000 && a <= 24'h37FFFF) f = {1'b1, 4'd13};
        else if (a >= 24'h3E0000 && a <= 24'h3FFFFF) f = {1'b1, 4'd14};
        else                                         f = {1'b0, 4'd0};
        return f;
    endfunction

endpackage

// ===== rtl/mdte_front.sv =====
// ----------------------------------------------------------------------------
// mdte_front: configuration registers and start decode
// Registers the configuration, decodes starts into a command record and
// passes step transactions through as step commands.
// ----------------------------------------------------------------------------
module mdte_front
    import mdte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_func,
    input  logic [15:0] in_word,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd,
    output logic [15:0] pattern
);

    logic [15:0] mode_reg;
    logic [31:0] first_reg;
    logic [31:0] second_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [15:0] pattern_reg;

    logic        valid_reg;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            count_reg   <= '0;
            pattern_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[15:0];
                REG_FIRST:   first_reg   <= cfg_data;
                REG_SECOND:  second_reg  <= cfg_data;
                REG_COUNT:   count_reg   <= cfg_data[COUNT_BITS-1:0];
                REG_PATTERN: pattern_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign pattern = pattern_reg;

    // Decode the start transaction
    always_comb
    begin
        logic [2:0]  op;
        logic        bad;
        logic        copy;
        logic [31:0] daddr;
        logic [4:0]  dst;
        logic [4:0]  src;
        logic [COUNT_BITS-1:0] cnt;
        bad = 1'b0;
        op  = OP_COPY;
        case (mode_reg)
            16'hFE3D, 16'hFE6D: op = OP_COPY;
            16'hE2DD, 16'hF2DD: op = OP_COPY_SPLIT;
            16'hFFC5, 16'hFF89: op = OP_DISC;
            16'hFC2D:           op = OP_DISC_SPLIT;
            16'hFEF5:           op = OP_FILL;
            16'hCFFD:           op = OP_FILL_SPLIT;
            16'hFFCD, 16'hFFDD: op = OP_PATTERN;
            default:            bad = 1'b1;
        endcase
        copy  = (op == OP_COPY) || (op == OP_COPY_SPLIT);
        daddr = copy ? first_reg : second_reg;
        dst   = find_region(daddr);
        src   = copy ? find_region(second_reg) : 5'b10000;
        cnt   = count_reg;
        if ((op == OP_DISC || op == OP_DISC_SPLIT) && cnt > COUNT_BITS'(DISC_MAX_STEPS))
            cnt = COUNT_BITS'(DISC_MAX_STEPS);

        cmd_next.is_step   = in_func;
        cmd_next.op        = op;
        cmd_next.wr_region = dst[3:0];
        cmd_next.rd_region = copy ? src[3:0] : 4'd0;
        cmd_next.wr_off    = daddr[OFF_W-1:0] & region_mask(dst[3:0]);
        cmd_next.rd_off    = copy ? (second_reg[OFF_W-1:0] & region_mask(src[3:0])) : '0;
        cmd_next.count     = cnt;
        cmd_next.fill_addr = second_reg;
        cmd_next.word      = in_word;
        if (bad)
            cmd_next.kind = K_BADMODE;
        else if (!dst[4] || !src[4])
            cmd_next.kind = K_NOREGION;
        else if (cnt == '0)
            cmd_next.kind = K_EMPTY;
        else
            cmd_next.kind = K_START;
    end

    // Output register toward the queue
    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cmd_reg <= cmd_next;
    end

endmodule

// ===== rtl/mdte_queue.sv =====
// ----------------------------------------------------------------------------
// mdte_queue: two-entry command queue
// Decouples the front end from the back end so each side stalls alone.
// ----------------------------------------------------------------------------
module mdte_queue
    import mdte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    cmd_t        mem_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_cmd   = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_cmd;
    end

endmodule

// ===== rtl/mdte_back.sv =====
// ----------------------------------------------------------------------------
// mdte_back: transfer sequencer
// Holds transfer state; emits one result per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module mdte_back
    import mdte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    input  logic [15:0] pattern,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    logic        busy_reg;
    logic [2:0]  op_reg;
    logic [COUNT_BITS-1:0] left_reg;
    logic [OFF_W-1:0] roff_reg;
    logic [OFF_W-1:0] woff_reg;
    logic [31:0] faddr_reg;
    logic [3:0]  rreg_reg;
    logic [3:0]  wreg_reg;
    logic [1:0]  idx_reg;

    logic        ovalid_reg;
    res_t        ores_reg;

    logic        emit;
    res_t        r;
    logic        done;
    logic        fin;
    logic        copy;
    logic [1:0]  nwr;
    logic [1:0]  nres;
    logic [15:0] w;
    logic [15:0] wd;
    logic        is_wr;

    assign emit      = cmd_valid && (!ovalid_reg || res_ready);
    assign res_valid = ovalid_reg;
    assign res       = ores_reg;
    assign cmd_ready = emit && done;

    // Select the result for the current sub-step
    always_comb
    begin
        fin  = left_reg <= COUNT_BITS'(1);
        copy = (op_reg == OP_COPY) || (op_reg == OP_COPY_SPLIT);
        w    = (copy && !region_read_ok(rreg_reg)) ? 16'hFFFF : cmd.word;
        case (op_reg)
            OP_COPY_SPLIT, OP_DISC_SPLIT, OP_FILL: nwr = 2'd1;
            OP_FILL_SPLIT:                         nwr = 2'd3;
            default:                               nwr = 2'd0;
        endcase
        case (op_reg)
            OP_COPY_SPLIT: wd = (idx_reg == 2'd0) ? {w[7:0], w[15:8]} : w;
            OP_DISC_SPLIT: wd = (idx_reg == 2'd0) ? {8'h00, w[15:8]} : w;
            OP_FILL:       wd = (idx_reg == 2'd0) ? faddr_reg[31:16] : faddr_reg[15:0];
            OP_FILL_SPLIT:
                case (idx_reg)
                    2'd0:    wd = {8'h00, faddr_reg[31:24]};
                    2'd1:    wd = faddr_reg[31:16];
                    2'd2:    wd = faddr_reg[23:8];
                    default: wd = faddr_reg[15:0];
                endcase
            OP_PATTERN:    wd = pattern;
            default:       wd = w;
        endcase
        nres  = (copy && !fin) ? nwr + 2'd1 : nwr;
        is_wr = idx_reg <= nwr;
        r = '0;
        if (!cmd.is_step)
        begin
            r.kind = cmd.kind;
            r.last = cmd.kind != K_START;
            if (cmd.kind == K_START || cmd.kind == K_EMPTY)
            begin
                r.region = cmd.wr_region;
                r.offset = cmd.wr_off;
            end
            if (idx_reg == 2'd1)
            begin
                r.kind   = K_READ;
                r.last   = 1'b0;
                r.region = cmd.rd_region;
                r.offset = cmd.rd_off & region_mask(cmd.rd_region);
            end
            done = !(cmd.kind == K_START &&
                     (cmd.op == OP_COPY || cmd.op == OP_COPY_SPLIT)) || idx_reg == 2'd1;
        end
        else if (!busy_reg)
        begin
            r.kind = K_IDLE;
            done   = 1'b1;
        end
        else
        begin
            if (is_wr)
            begin
                r.kind   = region_write_ok(wreg_reg) ? K_WRITE : K_DROP;
                r.region = wreg_reg;
                r.offset = woff_reg & region_mask(wreg_reg);
                r.data   = wd;
                r.last   = fin && (idx_reg == nwr);
            end
            else
            begin
                r.kind   = K_READ;
                r.region = rreg_reg;
                r.offset = roff_reg & region_mask(rreg_reg);
            end
            done = idx_reg == nres;
        end
    end

    // Advance transfer state per emitted result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            op_reg    <= '0;
            left_reg  <= '0;
            roff_reg  <= '0;
            woff_reg  <= '0;
            faddr_reg <= '0;
            rreg_reg  <= '0;
            wreg_reg  <= '0;
            idx_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (res_ready || !ovalid_reg)
                ovalid_reg <= emit;
            if (emit)
            begin
                idx_reg <= done ? 2'd0 : idx_reg + 2'd1;
                if (!cmd.is_step)
                begin
                    if (idx_reg == 2'd0)
                    begin
                        busy_reg <= cmd.kind == K_START;
                        if (cmd.kind == K_START || cmd.kind == K_EMPTY)
                        begin
                            op_reg    <= cmd.op;
                            left_reg  <= cmd.count;
                            woff_reg  <= cmd.wr_off;
                            roff_reg  <= cmd.rd_off;
                            rreg_reg  <= cmd.rd_region;
                            wreg_reg  <= cmd.wr_region;
                            faddr_reg <= cmd.fill_addr;
                        end
                    end
                    else
                        roff_reg <= roff_reg + OFF_W'(2);
                end
                else if (busy_reg)
                begin
                    if (is_wr)
                        woff_reg <= woff_reg + OFF_W'(2);
                    else
                        roff_reg <= roff_reg + OFF_W'(2);
                    if (done)
                    begin
                        left_reg <= fin ? '0 : left_reg - COUNT_BITS'(1);
                        if (fin)
                            busy_reg <= 1'b0;
                        if (op_reg == OP_FILL)
                            faddr_reg <= faddr_reg + 32'd4;
                        else if (op_reg == OP_FILL_SPLIT)
                            faddr_reg <= faddr_reg + 32'd8;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            ores_reg <= r;
    end

endmodule

// ===== rtl/multimode_dma_transfer_engine.sv =====
// ----------------------------------------------------------------------------
// multimode_dma_transfer_engine: top level of the multimode DMA engine
// A start transaction decodes the mode and regions; each step transaction
// then yields one to four word writes and, for copies, the next read request.
// Each result is one beat on the output channel, so a step yields one to
// four results (at most four for a byte-split address fill); the sequencer
// sets the rate, emitting one result per cycle while the output is not
// stalled. Inputs are accepted into a two-entry queue while the sequencer works.
// ----------------------------------------------------------------------------
module multimode_dma_transfer_engine
    import mdte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_word
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // access_kind, region_index, region_offset, write_data
    output logic        m_tlast    // last
);

    logic        fq_valid;
    logic        fq_ready;
    cmd_t        fq_cmd;
    logic        qb_valid;
    logic        qb_ready;
    cmd_t        qb_cmd;
    logic [15:0] pattern;
    res_t        res;

    mdte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_word   (s_tdata),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd),
        .pattern   (pattern)
    );

    mdte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    mdte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .pattern   (pattern),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {4'b0000, res.data, res.offset, res.region, res.kind};
    assign m_tlast = res.last;

endmodule
